### sv/cpso_pkg.sv
// ----------------------------------------------------------------------------
// cpso_pkg
// Command codes and sequencer states of the corner point set orderer.
// ----------------------------------------------------------------------------
`default_nettype none

package cpso_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_SELECT = 2'd1,
		CMD_LIST   = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL,
		ST_UPD,
		ST_RECT,
		ST_MINS,
		ST_CAND,
		ST_MUL,
		ST_CMP,
		ST_NEXT,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### sv/cpso_if.sv
// ----------------------------------------------------------------------------
// cpso_if
// Request and result channels of the corner point set orderer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpso_req_if #(
	parameter int COORD_BITS = 15
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic [COORD_BITS-1:0] click_x;
	logic [COORD_BITS-1:0] click_y;

	modport source (output valid, command, click_x, click_y, input ready);
	modport sink   (input valid, command, click_x, click_y, output ready);
endinterface

interface cpso_rsp_if #(
	parameter int COORD_BITS = 15
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic [1:0]            point_index;
	logic [2:0]            point_count;
	logic                  rect_valid;
	logic [COORD_BITS-1:0] rect_left;
	logic [COORD_BITS-1:0] rect_top;
	logic [COORD_BITS:0]   rect_width;
	logic [COORD_BITS:0]   rect_height;
	logic                  last;
	logic                  fault;

	modport source (output valid, point_x, point_y, point_index, point_count, rect_valid,
		rect_left, rect_top, rect_width, rect_height, last, fault, input ready);
	modport sink   (input valid, point_x, point_y, point_index, point_count, rect_valid,
		rect_left, rect_top, rect_width, rect_height, last, fault, output ready);
endinterface

`default_nettype wire

### sv/corner_point_set_orderer_core.sv
// ----------------------------------------------------------------------------
// corner_point_set_orderer_core
// Corner table with nearest-point select/add, bounding box and clockwise list.
// ----------------------------------------------------------------------------
// Scans: select/add, bounding box and list minimum walk the table one table
//   entry per cycle; the list walk takes each candidate through the multiplier.
// Commands: one at a time; the list walk through the shared multiplier bounds
//   the command rate.
// Reset: arst_n empties the table and drops the current point.
`default_nettype none

module corner_point_set_orderer_core #(
	parameter int MAX_CORNERS = 4,
	parameter int COORD_BITS  = 15
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cpso_req_if.sink   req,
	cpso_rsp_if.source rsp
);

	localparam int IW = $clog2(MAX_CORNERS);
	localparam int CW = $clog2(MAX_CORNERS + 1);
	localparam int CB = COORD_BITS;
	localparam int SW = COORD_BITS + 1;
	localparam int PW = 2 * SW;

	cpso_pkg::state_t state_q, state_d;
	cpso_pkg::cmd_t   cmd_q;

	logic [CB-1:0] mem_x_q [MAX_CORNERS];
	logic [CB-1:0] mem_y_q [MAX_CORNERS];
	logic [IW-1:0] order_q [MAX_CORNERS];
	logic [MAX_CORNERS-1:0] used_q;

	logic [CW-1:0] held_q, i_q, step_q, k_q;
	logic [IW-1:0] cur_slot_q, pick_q;
	logic          present_q, have_q, fault_q;
	logic [CB-1:0] clk_x_q, clk_y_q, best_d_q, min_q, ax_q, ay_q;
	logic [CB-1:0] sx_q, sy_q;
	logic [CB:0]   ex_q, ey_q;
	logic signed [SW-1:0] rx_q, ry_q, qx_q, qy_q;
	logic signed [PW-1:0] prod_q;

	logic          rsp_valid_q;
	logic [CB-1:0] o_x_q, o_y_q, o_left_q, o_top_q;
	logic [1:0]    o_idx_q;
	logic [2:0]    o_cnt_q;
	logic          o_rv_q, o_last_q, o_fault_q;
	logic [CB:0]   o_w_q, o_h_q;

	logic                 accept, i_end, emit_go, last_c, zero_pt, rv_c, take, q_zero, append;
	logic [IW-1:0]        rd_idx, wslot;
	logic [CB-1:0]        rd_x, rd_y, dx, dy, d, m;
	logic signed [SW-1:0] qx_c, qy_c, mul_a, mul_b;
	logic signed [PW-1:0] mul_p;

	assign accept = req.valid && req.ready;
	assign i_end  = (i_q == held_q);

	always_comb begin
		priority if (state_q == cpso_pkg::ST_EMIT && cmd_q == cpso_pkg::CMD_LIST)
			rd_idx = order_q[k_q[IW-1:0]];
		else if (state_q == cpso_pkg::ST_EMIT)
			rd_idx = cur_slot_q;
		else if (state_q == cpso_pkg::ST_NEXT)
			rd_idx = pick_q;
		else
			rd_idx = i_q[IW-1:0];
	end

	assign rd_x = mem_x_q[rd_idx];
	assign rd_y = mem_y_q[rd_idx];

	assign dx = (clk_x_q >= rd_x) ? clk_x_q - rd_x : rd_x - clk_x_q;
	assign dy = (clk_y_q >= rd_y) ? clk_y_q - rd_y : rd_y - clk_y_q;
	assign d  = (dx < dy) ? dx : dy;
	assign m  = (rd_x < rd_y) ? rd_x : rd_y;

	assign qx_c   = $signed({1'b0, rd_x}) - $signed({1'b0, ax_q});
	assign qy_c   = $signed({1'b0, rd_y}) - $signed({1'b0, ay_q});
	assign q_zero = (qx_c == '0) && (qy_c == '0);

	// shared multiplier: qy*rx in MUL, qx*ry in CMP
	assign mul_a = (state_q == cpso_pkg::ST_MUL) ? qy_q : qx_q;
	assign mul_b = (state_q == cpso_pkg::ST_MUL) ? rx_q : ry_q;
	assign mul_p = mul_a * mul_b;
	assign take  = prod_q < mul_p;

	assign append = (held_q == '0) || (best_d_q != '0 && held_q < CW'(MAX_CORNERS));
	assign wslot  = append ? held_q[IW-1:0] : pick_q;

	assign rv_c    = (held_q != '0) && (ex_q > {1'b0, sx_q}) && (ey_q > {1'b0, sy_q});
	assign zero_pt = fault_q || (cmd_q == cpso_pkg::CMD_CLEAR);
	assign last_c  = (cmd_q != cpso_pkg::CMD_LIST) || fault_q ||
		(k_q == CW'(held_q - 1'b1));
	assign emit_go = (state_q == cpso_pkg::ST_EMIT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			cpso_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (cpso_pkg::cmd_t'(req.command) == cpso_pkg::CMD_SELECT)
						state_d = (held_q == '0) ? cpso_pkg::ST_UPD : cpso_pkg::ST_SEL;
					else
						state_d = cpso_pkg::ST_RECT;
				end
			end
			cpso_pkg::ST_SEL: if (i_end) state_d = cpso_pkg::ST_UPD;
			cpso_pkg::ST_UPD: state_d = cpso_pkg::ST_RECT;
			cpso_pkg::ST_RECT: begin
				if (i_end)
					state_d = (cmd_q == cpso_pkg::CMD_LIST && held_q != '0) ?
						cpso_pkg::ST_MINS : cpso_pkg::ST_EMIT;
			end
			cpso_pkg::ST_MINS: if (i_end) state_d = cpso_pkg::ST_NEXT;
			cpso_pkg::ST_CAND: begin
				if (i_end)
					state_d = have_q ? cpso_pkg::ST_NEXT : cpso_pkg::ST_EMIT;
				else if (!used_q[i_q[IW-1:0]] && !q_zero && have_q)
					state_d = cpso_pkg::ST_MUL;
			end
			cpso_pkg::ST_MUL: state_d = cpso_pkg::ST_CMP;
			cpso_pkg::ST_CMP: state_d = cpso_pkg::ST_CAND;
			cpso_pkg::ST_NEXT: begin
				state_d = (CW'(step_q + 1'b1) == held_q) ? cpso_pkg::ST_EMIT :
					cpso_pkg::ST_CAND;
			end
			cpso_pkg::ST_EMIT: if (emit_go && last_c) state_d = cpso_pkg::ST_IDLE;
			default: state_d = cpso_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpso_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			cur_slot_q  <= '0;
			present_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept && cpso_pkg::cmd_t'(req.command) == cpso_pkg::CMD_CLEAR) begin
				held_q     <= '0;
				cur_slot_q <= '0;
				present_q  <= 1'b0;
			end
			if (state_q == cpso_pkg::ST_UPD) begin
				cur_slot_q <= wslot;
				present_q  <= 1'b1;
				if (append)
					held_q <= CW'(held_q + 1'b1);
			end
			if (emit_go)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			cpso_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_q   <= cpso_pkg::cmd_t'(req.command);
					clk_x_q <= req.click_x;
					clk_y_q <= req.click_y;
					i_q     <= '0;
				end
			end
			cpso_pkg::ST_SEL: begin
				if (!i_end) begin
					if (i_q == '0 || d < best_d_q) begin
						best_d_q <= d;
						pick_q   <= i_q[IW-1:0];
					end
					i_q <= CW'(i_q + 1'b1);
				end
			end
			cpso_pkg::ST_UPD: begin
				mem_x_q[wslot] <= clk_x_q;
				mem_y_q[wslot] <= clk_y_q;
				i_q            <= '0;
			end
			cpso_pkg::ST_RECT: begin
				if (!i_end) begin
					if (i_q == '0) begin
						sx_q <= rd_x;
						ex_q <= {1'b0, rd_x};
						sy_q <= rd_y;
						ey_q <= {1'b0, rd_y};
					end else begin
						if (rd_x < sx_q)
							sx_q <= rd_x;
						else if (ex_q <= {1'b0, rd_x})
							ex_q <= {1'b0, rd_x} + 1'b1;
						if (rd_y < sy_q)
							sy_q <= rd_y;
						else if (ey_q <= {1'b0, rd_y})
							ey_q <= {1'b0, rd_y} + 1'b1;
					end
					i_q <= CW'(i_q + 1'b1);
				end else begin
					i_q    <= '0;
					k_q    <= '0;
					step_q <= '0;
					used_q <= '0;
					have_q <= 1'b0;
					unique case (cmd_q)
						cpso_pkg::CMD_LIST: fault_q <= (held_q == '0);
						cpso_pkg::CMD_READ: fault_q <= !present_q ||
							({1'b0, cur_slot_q} >= (IW + 1)'(held_q));
						default:            fault_q <= 1'b0;
					endcase
				end
			end
			cpso_pkg::ST_MINS: begin
				if (!i_end) begin
					if (i_q == '0 || m < min_q) begin
						min_q  <= m;
						pick_q <= i_q[IW-1:0];
					end
					i_q <= CW'(i_q + 1'b1);
				end
			end
			cpso_pkg::ST_CAND: begin
				if (i_end) begin
					if (!have_q)
						fault_q <= 1'b1;
				end else if (used_q[i_q[IW-1:0]] || q_zero) begin
					i_q <= CW'(i_q + 1'b1);
				end else if (!have_q) begin
					rx_q   <= qx_c;
					ry_q   <= qy_c;
					pick_q <= i_q[IW-1:0];
					have_q <= 1'b1;
					i_q    <= CW'(i_q + 1'b1);
				end else begin
					qx_q <= qx_c;
					qy_q <= qy_c;
				end
			end
			cpso_pkg::ST_MUL: prod_q <= mul_p;
			cpso_pkg::ST_CMP: begin
				if (take) begin
					rx_q   <= qx_q;
					ry_q   <= qy_q;
					pick_q <= i_q[IW-1:0];
				end
				i_q <= CW'(i_q + 1'b1);
			end
			cpso_pkg::ST_NEXT: begin
				order_q[step_q[IW-1:0]] <= pick_q;
				used_q[pick_q]          <= 1'b1;
				ax_q                    <= rd_x;
				ay_q                    <= rd_y;
				step_q                  <= CW'(step_q + 1'b1);
				i_q                     <= '0;
				have_q                  <= 1'b0;
			end
			cpso_pkg::ST_EMIT: begin
				if (emit_go) begin
					o_x_q     <= zero_pt ? '0 : rd_x;
					o_y_q     <= zero_pt ? '0 : rd_y;
					o_idx_q   <= zero_pt ? 2'd0 : 2'(rd_idx);
					o_cnt_q   <= 3'(held_q);
					o_rv_q    <= rv_c;
					o_left_q  <= rv_c ? sx_q : '0;
					o_top_q   <= rv_c ? sy_q : '0;
					o_w_q     <= rv_c ? ex_q - {1'b0, sx_q} : '0;
					o_h_q     <= rv_c ? ey_q - {1'b0, sy_q} : '0;
					o_last_q  <= last_c;
					o_fault_q <= fault_q;
					k_q       <= CW'(k_q + 1'b1);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.point_x     = o_x_q;
	assign rsp.point_y     = o_y_q;
	assign rsp.point_index = o_idx_q;
	assign rsp.point_count = o_cnt_q;
	assign rsp.rect_valid  = o_rv_q;
	assign rsp.rect_left   = o_left_q;
	assign rsp.rect_top    = o_top_q;
	assign rsp.rect_width  = o_w_q;
	assign rsp.rect_height = o_h_q;
	assign rsp.last        = o_last_q;
	assign rsp.fault       = o_fault_q;

endmodule

`default_nettype wire

### sv/cpso_checker.sv
// ----------------------------------------------------------------------------
// cpso_checker
// Port-level checks on the result channel of the corner point set orderer.
// ----------------------------------------------------------------------------
`default_nettype none

module cpso_checker #(
	parameter int COORD_BITS = 15
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  valid,
	input wire logic                  ready,
	input wire logic [COORD_BITS-1:0] point_x,
	input wire logic [COORD_BITS-1:0] point_y,
	input wire logic [1:0]            point_index,
	input wire logic                  rect_valid,
	input wire logic [COORD_BITS-1:0] rect_left,
	input wire logic [COORD_BITS:0]   rect_width,
	input wire logic [COORD_BITS:0]   rect_height,
	input wire logic                  last,
	input wire logic                  fault
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(point_x) && $stable(last))
		else $error("result beat dropped or changed while stalled");

	a_fault_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && fault |-> last)
		else $error("fault beat is not final");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && fault |-> point_x == '0 && point_y == '0 && point_index == 2'd0)
		else $error("fault beat carries a point");

	a_rect: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !rect_valid |-> rect_width == '0 && rect_height == '0 && rect_left == '0)
		else $error("invalid rectangle not zeroed");

	a_rect_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rect_valid |-> rect_width != '0 && rect_height != '0)
		else $error("valid rectangle with zero size");

endmodule

bind corner_point_set_orderer_core cpso_checker #(.COORD_BITS(COORD_BITS)) u_cpso_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (rsp.valid),
	.ready       (rsp.ready),
	.point_x     (rsp.point_x),
	.point_y     (rsp.point_y),
	.point_index (rsp.point_index),
	.rect_valid  (rsp.rect_valid),
	.rect_left   (rsp.rect_left),
	.rect_width  (rsp.rect_width),
	.rect_height (rsp.rect_height),
	.last        (rsp.last),
	.fault       (rsp.fault)
);

`default_nettype wire
